// ===== hw/rtl/tcpopt_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpopt_pkg
// Shared constants, types and item structs of the TCP option parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpopt_pkg;

  localparam int MAX_SACK_BLOCKS = 4;

  // block index, block count and block store address widths
  localparam int IDX_W   = (MAX_SACK_BLOCKS > 1) ? $clog2(MAX_SACK_BLOCKS) : 1;
  localparam int CNT_W   = $clog2(MAX_SACK_BLOCKS + 1);
  localparam int RAM_DEPTH = 2 * MAX_SACK_BLOCKS;
  localparam int ADDR_W  = $clog2(RAM_DEPTH);
  localparam int BLK_W   = 64;

  localparam logic [7:0] KIND_END     = 8'd0;
  localparam logic [7:0] KIND_NOP     = 8'd1;
  localparam logic [7:0] KIND_MSS     = 8'd2;
  localparam logic [7:0] KIND_WS      = 8'd3;
  localparam logic [7:0] KIND_SACK_OK = 8'd4;
  localparam logic [7:0] KIND_SACK    = 8'd5;

  localparam logic [7:0] LEN_MSS     = 8'd4;
  localparam logic [7:0] LEN_WS      = 8'd3;
  localparam logic [7:0] LEN_SACK_OK = 8'd2;
  localparam logic [7:0] LEN_MIN     = 8'd2;

  typedef enum logic [2:0] {
    PH_KIND = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] option_byte;
    logic       has_byte;
    logic       end_of_options;
  } in_item_t;

  typedef struct packed {
    logic        is_block_item;
    logic        mss_seen;
    logic [15:0] mss;
    logic        wscale_seen;
    logic [7:0]  window_shift;
    logic        sack_perm_seen;
    logic [2:0]  num_blocks;
    logic [31:0] sack_left;
    logic [31:0] sack_right;
    logic        last_of_run;
  } out_item_t;

  // block store write request from the decoder
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] idx;
    logic [BLK_W-1:0] data;
  } blk_wr_t;

  // held option values as they stand after the current transaction
  typedef struct packed {
    logic             mss_seen;
    logic [15:0]      mss;
    logic             wscale_seen;
    logic [7:0]       window_shift;
    logic             sack_perm_seen;
    logic [CNT_W-1:0] count;
    logic             bank;
  } summary_t;

  typedef struct packed {
    logic busy;         // blocks still to read or deliver
    logic blocks_left;  // block reads still to issue
    logic bank;         // bank being read out
  } drain_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcp_option_parser.sv =====
// ----------------------------------------------------------------------------
// tcp_option_parser
// TCP options parser for MSS, window scale, SACK-permitted and SACK blocks.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one options byte per transaction (has_byte 0 gives an empty item),
//           end_of_options marks the closing transaction of an options area.
//   out_* : on the closing transaction, one summary item, then one item per
//           kept SACK block; last_of_run flags the final item of the area.
// Throughput: one byte transaction per cycle while no results are draining.
//   The closing transaction loads the summary into the output register and
//   its result appears the next cycle. SACK blocks come from the block RAM,
//   one read in flight at a time, so no block read is issued before the last one lands.
//   While blocks drain, byte transactions are still taken, except a closing
//   transaction or a SACK block write into the bank being read out.
// Reset (rst_n low, synchronous) clears the parser, drops any results not
//   yet delivered and leaves the block RAM contents undefined.
// A stalled receiver (out_ready low) holds the output register; the closing
//   transaction of the next area waits until all results are delivered.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_option_parser (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire tcpopt_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output tcpopt_pkg::out_item_t      out_data
);

  import tcpopt_pkg::*;

  blk_wr_t       wr;
  summary_t      summary;
  drain_status_t drain;
  logic          in_accept;
  logic          eoa_hold;
  logic          wr_hold;
  logic          ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic          rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [BLK_W-1:0]  rd_data;

  // Hold a closing transaction until the previous results are out and the
  // output register can take the summary.
  assign eoa_hold = in_data.end_of_options && (drain.busy || (out_valid && !out_ready));
  // Hold a block write aimed at the bank still being read out.
  assign wr_hold  = wr.en && drain.blocks_left && (wr.bank == drain.bank);

  assign in_ready  = !(eoa_hold || wr_hold);
  assign in_accept = in_valid && in_ready;

  assign ram_wr_en   = wr.en && in_accept;
  assign ram_wr_addr = ADDR_W'(wr.idx) + (wr.bank ? ADDR_W'(MAX_SACK_BLOCKS) : '0);

  tcpopt_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_data),
    .accept  (in_accept),
    .wr      (wr),
    .summary (summary)
  );

  tcpopt_block_ram #(
    .DEPTH (RAM_DEPTH),
    .WIDTH (BLK_W)
  ) u_block_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tcpopt_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_accept && in_data.end_of_options),
    .summary   (summary),
    .status    (drain),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_write_into_drain_bank: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en && drain.blocks_left |-> wr.bank != drain.bank)
    else $error("block write hit the bank being read out");

  a_close_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.end_of_options |-> !drain.busy)
    else $error("options area closed while results still draining");

  a_summary_follows_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.end_of_options |=> out_valid && !out_data.is_block_item)
    else $error("summary item missing after closing transaction");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tcpopt_block_ram.sv =====
// ----------------------------------------------------------------------------
// tcpopt_block_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpopt_block_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcpopt_decode.sv =====
// ----------------------------------------------------------------------------
// tcpopt_decode
// Kind/length walker: holds MSS, window scale, SACK-permitted and the SACK
// block counts, and issues block writes into the pending bank.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpopt_decode (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tcpopt_pkg::in_item_t in_item,
  input  wire logic                 accept,
  output tcpopt_pkg::blk_wr_t       wr,
  output tcpopt_pkg::summary_t      summary
);

  import tcpopt_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic             stopped_r, stopped_nxt;
  logic [7:0]       kind_r, kind_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       offset_r, offset_nxt;
  logic [31:0]      coll_r, coll_nxt;
  logic [31:0]      left_r, left_nxt;
  logic [15:0]      mss_r, mss_nxt;
  logic             mss_ok_r, mss_ok_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic             shift_ok_r, shift_ok_nxt;
  logic             sack_ok_r, sack_ok_nxt;
  logic [CNT_W-1:0] ccount_r, ccount_nxt;
  logic [CNT_W-1:0] pcount_r, pcount_nxt;
  logic             cbank_r, cbank_nxt;

  logic        act;
  logic        fin;
  logic [7:0]  fin_len;
  logic [31:0] fin_coll;
  logic [7:0]  rel;
  logic [4:0]  bidx;
  logic [2:0]  bpos;

  assign act  = in_item.has_byte && !stopped_r;
  assign rel  = offset_r - LEN_MIN;
  assign bidx = rel[7:3];
  assign bpos = rel[2:0];

  always_comb begin
    phase_nxt    = phase_r;
    stopped_nxt  = stopped_r;
    kind_nxt     = kind_r;
    len_nxt      = len_r;
    offset_nxt   = offset_r;
    coll_nxt     = coll_r;
    left_nxt     = left_r;
    mss_nxt      = mss_r;
    mss_ok_nxt   = mss_ok_r;
    shift_nxt    = shift_r;
    shift_ok_nxt = shift_ok_r;
    sack_ok_nxt  = sack_ok_r;
    ccount_nxt   = ccount_r;
    pcount_nxt   = pcount_r;
    cbank_nxt    = cbank_r;
    fin          = 1'b0;
    fin_len      = len_r;
    fin_coll     = coll_r;
    wr.en        = 1'b0;
    wr.bank      = !cbank_r;
    wr.idx       = bidx[IDX_W-1:0];
    wr.data      = {left_r, coll_r[23:0], in_item.option_byte};

    if (act) begin
      case (phase_r)
        PH_KIND: begin
          if (in_item.option_byte == KIND_END) begin
            stopped_nxt = 1'b1;
          end else if (in_item.option_byte != KIND_NOP) begin
            kind_nxt  = in_item.option_byte;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          len_nxt = in_item.option_byte;
          if (in_item.option_byte < LEN_MIN) begin
            stopped_nxt = 1'b1;
            phase_nxt   = PH_KIND;
          end else begin
            coll_nxt   = '0;
            offset_nxt = LEN_MIN;
            if (kind_r == KIND_SACK) begin
              pcount_nxt = '0;
            end
            if (in_item.option_byte == LEN_MIN) begin
              fin      = 1'b1;
              fin_len  = in_item.option_byte;
              fin_coll = '0;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          coll_nxt = {coll_r[23:0], in_item.option_byte};
          if (kind_r == KIND_SACK) begin
            if (bpos == 3'd3) begin
              left_nxt = coll_nxt;
            end
            if (bpos == 3'd7 && bidx < 5'(MAX_SACK_BLOCKS)) begin
              wr.en      = 1'b1;
              pcount_nxt = CNT_W'(bidx + 5'd1);
            end
          end
          offset_nxt = offset_r + 8'd1;
          if (offset_nxt >= len_r) begin
            fin      = 1'b1;
            fin_coll = coll_nxt;
          end
        end
        default: begin
          phase_nxt = PH_KIND;
        end
      endcase
    end

    // close out a complete option
    if (fin) begin
      phase_nxt = PH_KIND;
      if (kind_r == KIND_MSS && fin_len == LEN_MSS) begin
        mss_nxt    = fin_coll[15:0];
        mss_ok_nxt = 1'b1;
      end else if (kind_r == KIND_WS && fin_len == LEN_WS) begin
        shift_nxt    = fin_coll[7:0];
        shift_ok_nxt = 1'b1;
      end else if (kind_r == KIND_SACK_OK && fin_len == LEN_SACK_OK) begin
        sack_ok_nxt = 1'b1;
      end else if (kind_r == KIND_SACK) begin
        ccount_nxt = pcount_nxt;
        cbank_nxt  = !cbank_r;
      end
    end
  end

  always_comb begin
    summary.mss_seen       = mss_ok_nxt;
    summary.mss            = mss_ok_nxt ? mss_nxt : 16'd0;
    summary.wscale_seen    = shift_ok_nxt;
    summary.window_shift   = shift_ok_nxt ? shift_nxt : 8'd0;
    summary.sack_perm_seen = sack_ok_nxt;
    summary.count          = ccount_nxt;
    summary.bank           = cbank_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_item.end_of_options)) begin
      phase_r    <= PH_KIND;
      stopped_r  <= 1'b0;
      kind_r     <= '0;
      len_r      <= '0;
      offset_r   <= '0;
      coll_r     <= '0;
      left_r     <= '0;
      mss_r      <= '0;
      mss_ok_r   <= 1'b0;
      shift_r    <= '0;
      shift_ok_r <= 1'b0;
      sack_ok_r  <= 1'b0;
      ccount_r   <= '0;
      pcount_r   <= '0;
      cbank_r    <= rst_n ? cbank_nxt : 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      stopped_r  <= stopped_nxt;
      kind_r     <= kind_nxt;
      len_r      <= len_nxt;
      offset_r   <= offset_nxt;
      coll_r     <= coll_nxt;
      left_r     <= left_nxt;
      mss_r      <= mss_nxt;
      mss_ok_r   <= mss_ok_nxt;
      shift_r    <= shift_nxt;
      shift_ok_r <= shift_ok_nxt;
      sack_ok_r  <= sack_ok_nxt;
      ccount_r   <= ccount_nxt;
      pcount_r   <= pcount_nxt;
      cbank_r    <= cbank_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcpopt_drain.sv =====
// ----------------------------------------------------------------------------
// tcpopt_drain
// Result sequencer: loads the summary, reads the committed blocks from the
// block store one at a time and presents them in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpopt_drain (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire tcpopt_pkg::summary_t    summary,
  output tcpopt_pkg::drain_status_t    status,
  output logic                         rd_en,
  output logic [tcpopt_pkg::ADDR_W-1:0] rd_addr,
  input  wire logic [tcpopt_pkg::BLK_W-1:0] rd_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output tcpopt_pkg::out_item_t        out_data
);

  import tcpopt_pkg::*;

  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             bank_r, bank_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             rd_last_r, rd_last_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign rd_en     = (k_r != n_r) && !rd_pend_r && slot_free;
  assign rd_addr   = ADDR_W'(k_r[IDX_W-1:0]) + (bank_r ? ADDR_W'(MAX_SACK_BLOCKS) : '0);

  assign status.busy        = (k_r != n_r) || rd_pend_r;
  assign status.blocks_left = (k_r != n_r);
  assign status.bank        = bank_r;

  always_comb begin
    n_nxt         = n_r;
    k_nxt         = k_r;
    bank_nxt      = bank_r;
    rd_pend_nxt   = 1'b0;
    rd_last_nxt   = rd_last_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (start) begin
      n_nxt                       = summary.count;
      k_nxt                       = '0;
      bank_nxt                    = summary.bank;
      out_valid_nxt               = 1'b1;
      out_data_nxt                = '0;
      out_data_nxt.mss_seen       = summary.mss_seen;
      out_data_nxt.mss            = summary.mss;
      out_data_nxt.wscale_seen    = summary.wscale_seen;
      out_data_nxt.window_shift   = summary.window_shift;
      out_data_nxt.sack_perm_seen = summary.sack_perm_seen;
      out_data_nxt.num_blocks     = 3'(summary.count);
      out_data_nxt.last_of_run    = (summary.count == '0);
    end

    // advance to the next block read
    if (rd_en) begin
      k_nxt       = k_r + CNT_W'(1);
      rd_pend_nxt = 1'b1;
      rd_last_nxt = (k_nxt == n_r);
    end

    // read data lands in the now empty output register
    if (rd_pend_r) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt               = '0;
      out_data_nxt.is_block_item = 1'b1;
      out_data_nxt.sack_left     = rd_data[63:32];
      out_data_nxt.sack_right    = rd_data[31:0];
      out_data_nxt.last_of_run   = rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      k_r         <= '0;
      bank_r      <= 1'b0;
      rd_pend_r   <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      bank_r      <= bank_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_slot_free_on_return: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("block read returned into an occupied output register");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= n_r)
    else $error("block read index ran past the block count");

  a_last_block_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r && rd_last_r |=> out_valid_r && out_data_r.is_block_item && out_data_r.last_of_run)
    else $error("final block item not marked last");
`endif

endmodule

`default_nettype wire

// ===== verif/tcp_option_parser_test.sv =====
// ----------------------------------------------------------------------------
// tcp_option_parser_test
// Self-checking testbench for the TCP option parser. Options areas are fed
// one byte per transaction. A cycle-free predictor walks the same bytes and
// queues the summary and SACK block items that each closing transaction
// must produce. A monitor compares every delivered result field by field.
// Directed areas cover the edge cases. Random well-formed and broken areas
// follow, with idle bursts on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tcp_option_parser_test;
  import tcpopt_pkg::*;

  localparam int ITEM_TARGET    = 380;
  localparam int TAIL_ITEMS     = 110;  // left for the hold-off and closing tests
  localparam int HOLD_OFF_LEN   = 80;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 40;
  localparam int EDGE_BYTES     = 4;
  localparam int BLOCK_BYTES    = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  tcp_option_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shared test state
  // --------------------------------------------------------------------------
  out_item_t   expected_results[$];  // results still owed by the block
  logic [7:0]  area_bytes[$];        // options area being built for sending
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  bit          idle_on = 1'b0;       // both sides insert idle bursts
  int unsigned hold_request = 0;     // receiver hold-off length, 0 for none

  // --------------------------------------------------------------------------
  // Option walker: mirrors the parser state one accepted transaction at a time
  // --------------------------------------------------------------------------
  phase_t      walk_phase;
  logic        walk_stopped;
  logic [7:0]  opt_kind;
  logic [7:0]  opt_len;
  logic [7:0]  opt_offset;
  logic [31:0] value_acc;
  logic [31:0] left_acc;
  logic [15:0] mss_val;
  logic        mss_ok;
  logic [7:0]  shift_val;
  logic        shift_ok;
  logic        sack_ok;
  logic [63:0] kept_blocks[MAX_SACK_BLOCKS];
  int unsigned kept_n;
  logic [63:0] new_blocks[MAX_SACK_BLOCKS];
  int unsigned new_n;

  function automatic void clear_walker();
    walk_phase   = PH_KIND;
    walk_stopped = 1'b0;
    opt_kind     = '0;
    opt_len      = '0;
    opt_offset   = '0;
    value_acc    = '0;
    left_acc     = '0;
    mss_val      = '0;
    mss_ok       = 1'b0;
    shift_val    = '0;
    shift_ok     = 1'b0;
    sack_ok      = 1'b0;
    kept_n       = 0;
    new_n        = 0;
    for (int i = 0; i < MAX_SACK_BLOCKS; i++) begin
      kept_blocks[i] = '0;
      new_blocks[i]  = '0;
    end
  endfunction

  // Commit the option just completed; only exact lengths count for the
  // fixed-size kinds, while any complete SACK replaces the block list.
  function automatic void commit_option();
    if (opt_kind == KIND_MSS && opt_len == LEN_MSS) begin
      mss_val = value_acc[15:0];
      mss_ok  = 1'b1;
    end else if (opt_kind == KIND_WS && opt_len == LEN_WS) begin
      shift_val = value_acc[7:0];
      shift_ok  = 1'b1;
    end else if (opt_kind == KIND_SACK_OK && opt_len == LEN_SACK_OK) begin
      sack_ok = 1'b1;
    end else if (opt_kind == KIND_SACK) begin
      kept_blocks = new_blocks;
      kept_n      = new_n;
    end
    walk_phase = PH_KIND;
  endfunction

  function automatic void walk_option_byte(logic [7:0] b);
    int unsigned rel;
    int unsigned idx;
    case (walk_phase)
      PH_KIND: begin
        if (b == KIND_END) begin
          walk_stopped = 1'b1;
        end else if (b != KIND_NOP) begin
          opt_kind   = b;
          walk_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        opt_len = b;
        if (b < LEN_MIN) begin
          walk_stopped = 1'b1;
          walk_phase   = PH_KIND;
        end else begin
          value_acc  = '0;
          opt_offset = LEN_MIN;
          if (opt_kind == KIND_SACK) new_n = 0;
          if (b == LEN_MIN) commit_option();
          else walk_phase = PH_BODY;
        end
      end
      default: begin
        value_acc = {value_acc[23:0], b};
        if (opt_kind == KIND_SACK) begin
          rel = 32'(opt_offset - LEN_MIN);
          idx = rel / BLOCK_BYTES;
          // hold the left edge, then store the pair once the right edge is in
          if (rel % BLOCK_BYTES == EDGE_BYTES - 1) left_acc = value_acc;
          if (rel % BLOCK_BYTES == BLOCK_BYTES - 1 && idx < MAX_SACK_BLOCKS) begin
            new_blocks[idx] = {left_acc, value_acc};
            new_n = idx + 1;
          end
        end
        opt_offset = opt_offset + 8'd1;
        if (opt_offset >= opt_len) commit_option();
      end
    endcase
  endfunction

  // Apply one accepted transaction; on a closing one queue the summary and
  // the block items, then start the next area from a clean state.
  function automatic void predict_transaction(in_item_t it);
    out_item_t r;
    if (it.has_byte && !walk_stopped) walk_option_byte(it.option_byte);
    if (!it.end_of_options) return;
    r = '0;
    r.mss_seen       = mss_ok;
    r.mss            = mss_ok ? mss_val : 16'd0;
    r.wscale_seen    = shift_ok;
    r.window_shift   = shift_ok ? shift_val : 8'd0;
    r.sack_perm_seen = sack_ok;
    r.num_blocks     = 3'(kept_n);
    r.last_of_run    = (kept_n == 0);
    expected_results.push_back(r);
    for (int k = 0; k < kept_n; k++) begin
      r = '0;
      r.is_block_item = 1'b1;
      r.sack_left     = kept_blocks[k][63:32];
      r.sack_right    = kept_blocks[k][31:0];
      r.last_of_run   = (k + 1 == kept_n);
      expected_results.push_back(r);
    end
    clear_walker();
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Sample at the edge so the handshake and payload are the pre-edge values.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
      end else begin
        want = expected_results.pop_front();
        check_field("is_block_item", 32'(want.is_block_item), 32'(out_data.is_block_item));
        check_field("mss_seen", 32'(want.mss_seen), 32'(out_data.mss_seen));
        check_field("mss", 32'(want.mss), 32'(out_data.mss));
        check_field("wscale_seen", 32'(want.wscale_seen), 32'(out_data.wscale_seen));
        check_field("window_shift", 32'(want.window_shift), 32'(out_data.window_shift));
        check_field("sack_perm_seen", 32'(want.sack_perm_seen),
                    32'(out_data.sack_perm_seen));
        check_field("num_blocks", 32'(want.num_blocks), 32'(out_data.num_blocks));
        check_field("sack_left", want.sack_left, out_data.sack_left);
        check_field("sack_right", want.sack_right, out_data.sack_right);
        check_field("last_of_run", 32'(want.last_of_run), 32'(out_data.last_of_run));
      end
    end
  end

  // Count cycles with no transaction on either side; bail out if stuck.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready by default, random stall bursts while idling is on, and
  // one long hold-off on request. Assign out_ready once per edge.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        n = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Offer one transaction and hold it until accepted. An idle burst lowers
  // valid in the step of the previous acceptance, so valid never gets two
  // updates in one step.
  task automatic send_item(logic [7:0] b, logic has, logic eoa);
    in_item_t it;
    it.option_byte    = b;
    it.has_byte       = has;
    it.end_of_options = eoa;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_transaction(it);
    items_sent++;
  endtask

  // Send area_bytes, closing on the last byte or with an empty item.
  // Sprinkle empty non-closing items in at the given rate.
  task automatic send_area(bit empty_close, int unsigned blank_pct);
    int unsigned n;
    n = area_bytes.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < blank_pct) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(area_bytes[i], 1'b1, !empty_close && i == n - 1);
    end
    if (empty_close || n == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  function automatic void push_random_bytes(int unsigned count);
    repeat (count) area_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Build one random area: mostly well-formed options with random content,
  // some wrong lengths, stops and cut-off tails, and a share of pure noise.
  function automatic void build_random_area();
    int unsigned n_blocks;
    int unsigned len;
    area_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      push_random_bytes($urandom_range(1, 8));
      return;
    end
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 11))
        0, 1: begin
          area_bytes.push_back(KIND_MSS);
          area_bytes.push_back(LEN_MSS);
          push_random_bytes(32'(LEN_MSS - LEN_MIN));
        end
        2: begin
          area_bytes.push_back(KIND_WS);
          area_bytes.push_back(LEN_WS);
          push_random_bytes(32'(LEN_WS - LEN_MIN));
        end
        3: begin
          area_bytes.push_back(KIND_SACK_OK);
          area_bytes.push_back(LEN_SACK_OK);
        end
        4, 5, 6: begin
          // mostly up to the block limit, sometimes past it, some partial tails
          n_blocks = ($urandom_range(0, 5) == 0) ? $urandom_range(MAX_SACK_BLOCKS + 1,
                                                                  MAX_SACK_BLOCKS + 2)
                                                 : $urandom_range(0, MAX_SACK_BLOCKS);
          len = LEN_MIN + BLOCK_BYTES * n_blocks;
          if ($urandom_range(0, 3) == 0) len += $urandom_range(1, BLOCK_BYTES - 1);
          area_bytes.push_back(KIND_SACK);
          area_bytes.push_back(8'(len));
          push_random_bytes(len - LEN_MIN);
        end
        7: area_bytes.push_back(KIND_NOP);
        8: area_bytes.push_back(KIND_END);
        9: begin
          len = $urandom_range(LEN_MIN, 6);
          area_bytes.push_back(8'($urandom_range(KIND_SACK + 1, 255)));
          area_bytes.push_back(8'(len));
          push_random_bytes(len - LEN_MIN);
        end
        10: begin
          // known kind with any length, usually the wrong one
          len = $urandom_range(LEN_MIN, 7);
          area_bytes.push_back(8'($urandom_range(KIND_MSS, KIND_SACK_OK)));
          area_bytes.push_back(8'(len));
          push_random_bytes(len - LEN_MIN);
        end
        default: begin
          area_bytes.push_back(8'($urandom_range(KIND_MSS, 255)));
          area_bytes.push_back(8'($urandom_range(0, LEN_MIN - 1)));
          push_random_bytes($urandom_range(0, 3));
        end
      endcase
    end
    // cut the tail off now and then so the last option is incomplete
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) if (area_bytes.size() > 0) void'(area_bytes.pop_back());
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_empty_area();
    area_bytes.delete();
    send_area(1'b1, 0);
  endtask

  // A NOP, largest MSS, zero shift, SACK-permitted, then END with a byte
  // behind it that must be dropped.
  task automatic test_single_options();
    area_bytes = '{KIND_NOP, KIND_MSS, LEN_MSS, 8'hff, 8'hff, KIND_WS, LEN_WS, 8'h00,
                   KIND_SACK_OK, LEN_SACK_OK, KIND_END, 8'hff};
    send_area(1'b0, 0);
  endtask

  // A length below the minimum stops the walk; an unknown kind is skipped
  // by its length; a kind byte as the final byte is a cut-off option. An
  // empty item in the middle must change nothing.
  task automatic test_stops_and_cutoffs();
    area_bytes = '{KIND_WS, 8'h01, KIND_MSS, LEN_MSS, 8'h12, 8'h34};
    send_area(1'b0, 0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h03, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(KIND_MSS, 1'b1, 1'b1);
  endtask

  // One SACK block with extreme edges.
  task automatic test_sack_block();
    area_bytes = '{KIND_SACK, 8'(LEN_MIN + BLOCK_BYTES), 8'hff, 8'hff, 8'hff, 8'hff,
                   8'h00, 8'h00, 8'h00, 8'h00};
    send_area(1'b0, 0);
  endtask

  task automatic test_random_areas();
    while (items_sent < ITEM_TARGET - TAIL_ITEMS) begin
      // switch idling per area so some stretches run without gaps
      idle_on = ($urandom_range(0, 2) != 0);
      build_random_area();
      send_area($urandom_range(0, 3) == 0, 8);
    end
  endtask

  // Hold the receiver off while SACK areas keep coming, so the block fills
  // up and must stall its input.
  task automatic test_receiver_hold_off();
    idle_on = 1'b0;
    hold_request = HOLD_OFF_LEN;
    repeat (3) begin
      area_bytes.delete();
      area_bytes.push_back(KIND_SACK);
      area_bytes.push_back(8'(LEN_MIN + 2 * BLOCK_BYTES));
      push_random_bytes(2 * BLOCK_BYTES);
      send_area(1'b0, 0);
    end
  endtask

  // Finish with back-to-back traffic and no idling on either side.
  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (3) begin
      build_random_area();
      send_area($urandom_range(0, 3) == 0, 0);
    end
  endtask

  initial begin
    clear_walker();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_area();
    test_single_options();
    test_stops_and_cutoffs();
    test_sack_block();
    test_random_areas();
    test_receiver_hold_off();
    test_back_to_back();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // watch a little longer for stray results
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
